// ----- src/ahfd_pkg.sv -----
// Shared types, constants and the character conversion for the hex frame decoder.
`default_nettype none

package ahfd_pkg;

	localparam logic [4:0] LAST_POS    = 5'd18;
	localparam logic [7:0] START_CHAR  = 8'd35;
	localparam logic [7:0] END_CHAR    = 8'd88;
	localparam logic [7:0] LETTER_BASE = 8'd65;
	localparam logic [7:0] LETTER_OFS  = 8'd55;
	localparam logic [7:0] DIGIT_OFS   = 8'd48;
	localparam logic [3:0] DATA_BYTES  = 4'd8;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_START,
		OP_ID_HI,
		OP_ID_LO,
		OP_DATA_HI,
		OP_DATA_LO
	} op_t;

	// One classified character on its way from the front to the back.
	typedef struct packed {
		op_t        op;
		logic [7:0] nib;
		logic       hit;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [7:0]      id;
		logic [3:0]      len;
		logic [7:0][7:0] data;
	} result_t;

	// Characters from 'A' upwards count from 'A' as ten, all others from '0'.
	function automatic logic [7:0] nibble_of(input logic [7:0] c);
		if (c >= LETTER_BASE) begin
			return c - LETTER_OFS;
		end
		return c - DIGIT_OFS;
	endfunction

endpackage

`default_nettype wire

// ----- src/ahfd_front.sv -----
// Front end: counts frame positions and classifies each received character.
`default_nettype none

module ahfd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rx_valid,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          q_full,
	output logic               rx_stall,
	output logic               push,
	output ahfd_pkg::cmd_t     push_cmd
);
	import ahfd_pkg::*;

	logic [4:0] pos_q;
	logic       last;

	assign rx_stall = q_full;
	assign push     = rx_valid && !q_full;
	assign last     = (pos_q >= LAST_POS);

	always_comb begin
		push_cmd.nib  = nibble_of(rx_byte);
		push_cmd.last = last;
		push_cmd.hit  = 1'b0;
		unique case (pos_q)
			5'd0: begin
				push_cmd.op  = OP_START;
				push_cmd.hit = (rx_byte == START_CHAR);
			end
			5'd1: push_cmd.op = OP_ID_HI;
			5'd2: push_cmd.op = OP_ID_LO;
			default: begin
				if (pos_q[0]) begin
					push_cmd.op  = OP_DATA_HI;
					push_cmd.hit = (rx_byte == END_CHAR);
				end else begin
					push_cmd.op = OP_DATA_LO;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 5'd0;
		end else if (push) begin
			pos_q <= last ? 5'd0 : pos_q + 5'd1;
		end
	end

endmodule

`default_nettype wire

// ----- src/ahfd_queue.sv -----
// Short command queue between the front end and the back end.
`default_nettype none

module ahfd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ahfd_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output logic                full,
	output logic                q_valid,
	output ahfd_pkg::cmd_t      q_cmd
);
	import ahfd_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ----- src/ahfd_back.sv -----
// Back end: builds the identifier and data bytes and holds the finished message.
`default_nettype none

module ahfd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire ahfd_pkg::cmd_t q_cmd,
	input  wire logic           msg_stall,
	output logic                pop,
	output logic                msg_valid,
	output ahfd_pkg::result_t   result
);
	import ahfd_pkg::*;

	logic            accepted_q, accepted_d;
	logic            ended_q, ended_d;
	logic [7:0]      id_q, id_d;
	logic [3:0]      count_q, count_d;
	logic [7:0][7:0] store_q, store_d;
	logic [2:0]      slot;
	logic            out_free;
	logic            emit;

	assign slot     = count_q[2:0];
	assign out_free = !msg_valid || !msg_stall;
	assign pop      = q_valid && (!q_cmd.last || out_free);
	assign emit     = pop && q_cmd.last && accepted_d;

	always_comb begin
		accepted_d = accepted_q;
		ended_d    = ended_q;
		id_d       = id_q;
		count_d    = count_q;
		store_d    = store_q;
		unique case (q_cmd.op)
			OP_START: begin
				accepted_d = q_cmd.hit;
				ended_d    = 1'b0;
				id_d       = 8'd0;
				count_d    = 4'd0;
				store_d    = '0;
			end
			OP_ID_HI: id_d = {q_cmd.nib[3:0], 4'h0};
			OP_ID_LO: id_d = id_q + q_cmd.nib;
			OP_DATA_HI: begin
				if (!ended_q) begin
					if (q_cmd.hit || count_q >= DATA_BYTES) begin
						ended_d = 1'b1;
					end else begin
						store_d[slot] = {q_cmd.nib[3:0], 4'h0};
					end
				end
			end
			OP_DATA_LO: begin
				if (!ended_q) begin
					store_d[slot] = store_q[slot] + q_cmd.nib;
					count_d       = count_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= 1'b0;
			ended_q    <= 1'b0;
			id_q       <= 8'd0;
			count_q    <= 4'd0;
			store_q    <= '0;
			msg_valid  <= 1'b0;
		end else begin
			if (pop) begin
				accepted_q <= accepted_d;
				ended_q    <= ended_d;
				id_q       <= id_d;
				count_q    <= count_d;
				store_q    <= store_d;
			end
			if (msg_valid && !msg_stall) begin
				msg_valid <= 1'b0;
			end
			if (emit) begin
				msg_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result.id   <= id_d;
			result.len  <= count_d;
			result.data <= store_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/ascii_hex_frame_decoder.sv -----
// Top level of the ASCII hex frame decoder: front end, command queue and back end.
// Throughput is one character per cycle while rx_stall is low; the back end updates on each pop.
// A message is registered on msg_valid once the back end pops its frame's nineteenth character.
// While a message waits under msg_stall the next frame's last character stays queued, and
// rx_stall rises once one more beat has filled the queue behind it.
// Reset (arst_n, asynchronous, active low) restarts frame counting and clears all control state.
`default_nettype none

module ascii_hex_frame_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	output logic            msg_valid,
	input  wire logic       msg_stall,
	output logic [7:0]      msg_id,
	output logic [3:0]      msg_length,
	output logic [7:0]      byte0,
	output logic [7:0]      byte1,
	output logic [7:0]      byte2,
	output logic [7:0]      byte3,
	output logic [7:0]      byte4,
	output logic [7:0]      byte5,
	output logic [7:0]      byte6,
	output logic [7:0]      byte7
);
	import ahfd_pkg::*;

	// The front end turns each character beat into a command: its role in the
	// frame, its nibble value and whether it is the start or end marker.
	logic    push;
	cmd_t    push_cmd;
	logic    q_full;
	logic    q_valid;
	cmd_t    q_cmd;
	logic    pop;
	result_t result;

	ahfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.rx_stall (rx_stall),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// The queue lets the front end keep taking beats while the back end
	// waits for a finished message to be collected.
	ahfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd)
	);

	// The back end holds the frame state and the message output register.
	ahfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.msg_stall (msg_stall),
		.pop       (pop),
		.msg_valid (msg_valid),
		.result    (result)
	);

	assign msg_id     = result.id;
	assign msg_length = result.len;
	assign byte0      = result.data[0];
	assign byte1      = result.data[1];
	assign byte2      = result.data[2];
	assign byte3      = result.data[3];
	assign byte4      = result.data[4];
	assign byte5      = result.data[5];
	assign byte6      = result.data[6];
	assign byte7      = result.data[7];

`ifndef NO_ASSERTIONS
	// An accepted beat is always visible in the queue on the next cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_valid && !rx_stall) |=> q_valid)
		else $error("accepted beat did not reach the queue");

	// A new message only appears after the back end consumed a frame's last beat.
	a_msg_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(msg_valid) |-> $past(pop && q_cmd.last))
		else $error("message raised without a final beat");

	// A message never reports more data bytes than a frame can carry.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid |-> (msg_length <= DATA_BYTES))
		else $error("message length out of range");

	// The back end never drains a final beat into a busy output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_cmd.last) |-> (!msg_valid || !msg_stall))
		else $error("final beat consumed while message held");
`endif

endmodule

`default_nettype wire

// ----- bench/ahfd_checker.sv -----
// Checker that predicts and compares the decoded messages of the ASCII hex frame decoder.
`default_nettype none

module ahfd_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	input  wire logic       rx_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       msg_valid,
	input  wire logic       msg_stall,
	input  wire logic [7:0] msg_id,
	input  wire logic [3:0] msg_length,
	input  wire logic [7:0] byte0,
	input  wire logic [7:0] byte1,
	input  wire logic [7:0] byte2,
	input  wire logic [7:0] byte3,
	input  wire logic [7:0] byte4,
	input  wire logic [7:0] byte5,
	input  wire logic [7:0] byte6,
	input  wire logic [7:0] byte7,
	output int              errors,
	output int              pending,
	output int              checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import ahfd_pkg::*;

	typedef struct packed {
		logic [7:0]      id;
		logic [3:0]      len;
		logic [7:0][7:0] data;
	} decoded_msg_t;

	decoded_msg_t    expected_msgs[$];

	// Decoder state as seen from outside.
	logic [4:0]      char_pos;
	logic            frame_ok;
	logic            data_done;
	logic [7:0]      id_acc;
	logic [7:0][7:0] data_acc;
	logic [3:0]      bytes_done;

	function automatic logic [7:0] hex_value(input logic [7:0] ch);
		if (ch >= LETTER_BASE) begin
			return ch - LETTER_OFS;
		end
		return ch - DIGIT_OFS;
	endfunction

	function automatic op_t role_of(input logic [4:0] pos);
		if (pos == 5'd0) begin
			return OP_START;
		end else if (pos == 5'd1) begin
			return OP_ID_HI;
		end else if (pos == 5'd2) begin
			return OP_ID_LO;
		end else if (pos[0]) begin
			return OP_DATA_HI;
		end
		return OP_DATA_LO;
	endfunction

	function automatic int field_differs(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Advances the prediction by one accepted character beat.
	task automatic decode_char(input logic [7:0] ch);
		logic [7:0]   nib;
		logic [2:0]   slot;
		decoded_msg_t m;
		nib  = hex_value(ch);
		slot = bytes_done[2:0];
		case (role_of(char_pos))
			OP_START: begin
				frame_ok   = (ch == START_CHAR);
				data_done  = 1'b0;
				id_acc     = '0;
				data_acc   = '0;
				bytes_done = '0;
			end
			OP_ID_HI: begin
				id_acc = {nib[3:0], 4'h0};
			end
			OP_ID_LO: begin
				id_acc = id_acc + nib;
			end
			OP_DATA_HI: begin
				if (!data_done) begin
					if (ch == END_CHAR || bytes_done >= DATA_BYTES) begin
						data_done = 1'b1;
					end else begin
						data_acc[slot] = {nib[3:0], 4'h0};
					end
				end
			end
			default: begin
				if (!data_done) begin
					data_acc[slot] = data_acc[slot] + nib;
					bytes_done     = bytes_done + 4'd1;
				end
			end
		endcase
		if (char_pos == LAST_POS) begin
			if (frame_ok) begin
				m.id   = id_acc;
				m.len  = bytes_done;
				m.data = data_acc;
				expected_msgs.push_back(m);
			end
			char_pos = '0;
		end else begin
			char_pos = char_pos + 5'd1;
		end
	endtask

	task automatic compare_msg();
		decoded_msg_t    want;
		logic [7:0][7:0] got_data;
		int              bad;
		if (expected_msgs.size() == 0) begin
			$display("%0t: message with none expected, actual id %02h length %0d",
				$time, msg_id, msg_length);
			errors++;
			return;
		end
		want     = expected_msgs.pop_front();
		got_data = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
		bad      = field_differs("msg_id", want.id, msg_id);
		bad     += field_differs("msg_length", {4'h0, want.len}, {4'h0, msg_length});
		for (int k = 0; k < 8; k++) begin
			bad += field_differs($sformatf("byte%0d", k), want.data[k], got_data[k]);
		end
		errors += bad;
		checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_pos   = '0;
			frame_ok   = 1'b0;
			data_done  = 1'b0;
			id_acc     = '0;
			data_acc   = '0;
			bytes_done = '0;
			expected_msgs.delete();
			errors     = 0;
			checked    = 0;
		end else begin
			if (rx_valid && !rx_stall) begin
				decode_char(rx_byte);
			end
			if (msg_valid && !msg_stall) begin
				compare_msg();
			end
		end
		pending = expected_msgs.size();
	end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Top of the bench for the ASCII hex frame decoder: clock, reset, frame stimulus and verdict.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ahfd_pkg::*;

	// One frame is always nineteen characters; frames are counted from reset, so the
	// stimulus only ever sends whole frames to keep the block and the bench aligned.
	localparam int FRAME_CHARS  = 19;
	localparam int RANDOM_FRAMES = 97;
	// The final frames run with no idling on either side.
	localparam int CALM_FRAMES  = 12;
	// Frame at which the message side holds off for a long stretch.
	localparam int HOLD_FRAME   = 40;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [7:0] CH_A    = "A";

	logic       clk = 1'b0;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_stall;
	logic [7:0] rx_byte;
	logic       msg_valid;
	logic       msg_stall;
	logic [7:0] msg_id;
	logic [3:0] msg_length;
	logic [7:0] byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;

	int errors;
	int pending;
	int checked;

	// Shared between the character sender and the message receiver.
	bit idling_on;
	bit hold_request;
	bit hold_busy;

	logic [7:0] frame_chars [FRAME_CHARS];
	int frames_sent;
	int start_frames;
	int hold_stall_beats;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	ascii_hex_frame_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.msg_id     (msg_id),
		.msg_length (msg_length),
		.byte0      (byte0),
		.byte1      (byte1),
		.byte2      (byte2),
		.byte3      (byte3),
		.byte4      (byte4),
		.byte5      (byte5),
		.byte6      (byte6),
		.byte7      (byte7)
	);

	ahfd_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.msg_id     (msg_id),
		.msg_length (msg_length),
		.byte0      (byte0),
		.byte1      (byte1),
		.byte2      (byte2),
		.byte3      (byte3),
		.byte4      (byte4),
		.byte5      (byte5),
		.byte6      (byte6),
		.byte7      (byte7),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked)
	);

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) begin
			return CH_ZERO + v;
		end
		return CH_A + (v - 4'd10);
	endfunction

	// Mostly proper hex characters, but now and then any byte at all, so that
	// out-of-range characters and the wrapping conversion are exercised too.
	function automatic logic [7:0] random_char();
		if ($urandom_range(0, 4) != 0) begin
			return hex_char(4'($urandom_range(0, 15)));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// The opening frame is written out by hand. The identifier holds an 'X', which
	// must count as an ordinary character there, and a zero byte that wraps. The
	// data then carry FF, a non-hex pair of which only the first wraps and a pair whose
	// second character is 'X'. The fourth pair starts with 'X' and ends the data,
	// after which further 'X's, a stray '#' and FF bytes must all be ignored.
	task automatic build_directed_frame();
		frame_chars = '{START_CHAR, END_CHAR, 8'h00, "F", "F", 8'h00, 8'hFF, "0", END_CHAR,
			END_CHAR, END_CHAR, END_CHAR, START_CHAR, 8'hFF, END_CHAR, 8'hFF, 8'h00,
			8'hFF, END_CHAR};
	endtask

	// Most frames are well formed with random content and a random data length,
	// ended early by a single 'X' opening the next pair when shorter than eight
	// bytes. Some frames start with something other than '#', and some are pure noise.
	task automatic build_random_frame(input bit force_start);
		int data_len;
		logic [7:0] first;
		if ($urandom_range(0, 9) == 0) begin
			foreach (frame_chars[i]) begin
				frame_chars[i] = 8'($urandom_range(0, 255));
			end
		end else begin
			if ($urandom_range(0, 7) == 0) begin
				do begin
					first = 8'($urandom_range(0, 255));
				end while (first == START_CHAR);
				frame_chars[0] = first;
			end else begin
				frame_chars[0] = START_CHAR;
			end
			frame_chars[1] = random_char();
			frame_chars[2] = random_char();
			data_len = ($urandom_range(0, 2) == 0) ? 8 : $urandom_range(0, 8);
			for (int i = 3; i < FRAME_CHARS; i++) begin
				frame_chars[i] = random_char();
			end
			if (data_len < 8) begin
				frame_chars[3 + 2 * data_len] = END_CHAR;
			end
		end
		if (force_start) begin
			frame_chars[0] = START_CHAR;
		end
	endtask

	// Offers one character beat. It is entered at a falling edge and returns at the
	// falling edge after the beat was taken, with valid still high so that the next
	// beat can follow back to back.
	task automatic send_char(input logic [7:0] ch);
		rx_byte  <= ch;
		rx_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (rx_stall);
		@(negedge clk);
	endtask

	// Sends the frame held in frame_chars. Gaps fall before any character, so the
	// sender idles at every position of the frame over the run. While the long
	// hold is in progress the sender offers back to back so that the block fills.
	task automatic send_frame();
		for (int i = 0; i < FRAME_CHARS; i++) begin
			if (idling_on && !hold_busy && $urandom_range(0, 5) == 0) begin
				rx_valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			send_char(frame_chars[i]);
		end
		frames_sent++;
		if (frame_chars[0] == START_CHAR) begin
			start_frames++;
		end
	endtask

	// Message side: random stall bursts while idling is on, and once a long hold
	// when the sender asks for it.
	initial begin
		msg_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_busy    = 1'b1;
				msg_stall   <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				msg_stall   <= 1'b0;
				hold_busy    = 1'b0;
			end else if (idling_on && $urandom_range(0, 6) == 0) begin
				msg_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				msg_stall <= 1'b0;
			end
		end
	end

	// Counts the cycles in which the block refuses a character during the long
	// hold, which shows that the back pressure reached the input side.
	always @(posedge clk) begin
		if (hold_busy && rx_valid && rx_stall) begin
			hold_stall_beats++;
		end
	end

	initial begin
		int guard;
		arst_n           = 1'b0;
		rx_valid         = 1'b0;
		rx_byte          = 8'h00;
		idling_on        = 1'b0;
		hold_request     = 1'b0;
		hold_busy        = 1'b0;
		frames_sent      = 0;
		start_frames     = 0;
		hold_stall_beats = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		build_directed_frame();
		send_frame();

		for (int f = 0; f < RANDOM_FRAMES; f++) begin
			// Idling is switched per frame, leaving stretches that run flat out,
			// and it stays off altogether for the closing frames.
			idling_on = (f < RANDOM_FRAMES - CALM_FRAMES) && ($urandom_range(0, 3) != 0);
			if (f == HOLD_FRAME) begin
				hold_request = 1'b1;
			end
			build_random_frame(f == HOLD_FRAME);
			send_frame();
		end
		rx_valid <= 1'b0;

		// Let the last messages drain, then let the pipeline settle in case
		// anything unexpected is still on its way out.
		guard = 0;
		while (pending != 0 && guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Run covered %0d frames (%0d starting with '#') of %0d characters each.",
			frames_sent, start_frames, FRAME_CHARS);
		$display("%0d messages compared; input held back on %0d beats during the long hold.",
			checked, hold_stall_beats);
		if (pending != 0) begin
			$display("%0t: %0d expected messages never arrived", $time, pending);
		end
		if (errors == 0 && pending == 0) begin
			$display("** ascii_hex_frame_decoder: PASSED **");
		end else begin
			$display("** ascii_hex_frame_decoder: FAILED **");
		end
		$finish;
	end

	// Hard stop in case the handshakes ever lock up.
	initial begin
		#1_000_000;
		$display("%0t: run timed out", $time);
		$display("** ascii_hex_frame_decoder: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
